FILE: src/sme_pkg.sv
// shared types and constants of the stack machine executor
package sme_pkg;

    localparam int CMD_W    = 4;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        OP_HALT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_NOR   = 4'd2,
        OP_IFZ   = 4'd3,
        OP_LOAD  = 4'd4,
        OP_STORE = 4'd5,
        OP_POP   = 4'd6,
        OP_PUSHI = 4'd7,
        OP_NOOP  = 4'd8
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SKIP     = 3'd1,
        ST_HALTED   = 3'd2,
        ST_UNDER    = 3'd3,
        ST_OVER     = 3'd4,
        ST_BAD_ADDR = 3'd5
    } t_status;

    // how the stack pointer moves
    typedef enum logic [1:0] {
        SP_HOLD,
        SP_INC,
        SP_DEC1,
        SP_DEC2
    } t_sp_op;

    // stack write address relative to the current pointer
    typedef enum logic [1:0] {
        WS_AT,
        WS_M1,
        WS_M2
    } t_wsel;

    typedef struct packed {
        logic empty;
        logic lt2;
        logic full;
        logic addr_ok;
        logic dm_ok;
        logic halted;
    } t_step_flags;

    typedef struct packed {
        logic              wait_dm;
        t_status           status;
        logic [WORD_W-1:0] mem_value;
        logic              stk_we;
        t_wsel             wsel;
        logic [WORD_W-1:0] stk_wdata;
        logic              dm_we;
        t_sp_op            sp_op;
        logic              halt;
        logic [WORD_W-1:0] skip;
    } t_step_res;

endpackage

FILE: src/sme_step.sv
// decode and execute logic for one instruction
module sme_step (
    input  logic [sme_pkg::CMD_W-1:0]  i_cmd,
    input  logic [sme_pkg::WORD_W-1:0] i_operand,
    input  logic [sme_pkg::WORD_W-1:0] i_top,
    input  logic [sme_pkg::WORD_W-1:0] i_second,
    input  logic [sme_pkg::WORD_W-1:0] i_dm_data,
    input  logic [sme_pkg::WORD_W-1:0] i_skip,
    input  sme_pkg::t_step_flags       i_flags,
    output sme_pkg::t_step_res         o_res
);

    always_comb begin
        o_res           = '0;
        o_res.status    = sme_pkg::ST_OK;
        o_res.wsel      = sme_pkg::WS_AT;
        o_res.sp_op     = sme_pkg::SP_HOLD;
        o_res.halt      = i_flags.halted;
        o_res.skip      = i_skip;
        if (i_flags.halted) begin
            o_res.status = sme_pkg::ST_HALTED;
        end else if (i_skip != '0) begin
            o_res.status = sme_pkg::ST_SKIP;
            o_res.skip   = i_skip - sme_pkg::WORD_W'(1);
        end else begin
            case (sme_pkg::t_opcode'(i_cmd))
                sme_pkg::OP_HALT: begin
                    o_res.halt = 1'b1;
                end
                sme_pkg::OP_ADD, sme_pkg::OP_NOR: begin
                    if (i_flags.lt2) begin
                        o_res.status = sme_pkg::ST_UNDER;
                    end else begin
                        o_res.stk_we    = 1'b1;
                        o_res.wsel      = sme_pkg::WS_M2;
                        o_res.stk_wdata = (sme_pkg::t_opcode'(i_cmd) == sme_pkg::OP_ADD)
                                          ? i_top + i_second : ~(i_top | i_second);
                        o_res.sp_op     = sme_pkg::SP_DEC1;
                    end
                end
                sme_pkg::OP_IFZ: begin
                    if (i_flags.empty) begin
                        o_res.status = sme_pkg::ST_UNDER;
                    end else begin
                        o_res.sp_op = sme_pkg::SP_DEC1;
                        if (i_top == '0 && !i_operand[sme_pkg::WORD_W-1]) begin
                            o_res.skip = i_operand;
                        end
                    end
                end
                sme_pkg::OP_LOAD: begin
                    if (i_flags.empty) begin
                        o_res.status = sme_pkg::ST_UNDER;
                    end else if (!i_flags.addr_ok) begin
                        o_res.status = sme_pkg::ST_BAD_ADDR;
                    end else if (!i_flags.dm_ok) begin
                        o_res.wait_dm = 1'b1;
                    end else begin
                        o_res.stk_we    = 1'b1;
                        o_res.wsel      = sme_pkg::WS_M1;
                        o_res.stk_wdata = i_dm_data;
                        o_res.mem_value = i_dm_data;
                    end
                end
                sme_pkg::OP_STORE: begin
                    if (i_flags.lt2) begin
                        o_res.status = sme_pkg::ST_UNDER;
                    end else if (!i_flags.addr_ok) begin
                        o_res.status = sme_pkg::ST_BAD_ADDR;
                    end else begin
                        o_res.dm_we     = 1'b1;
                        o_res.mem_value = i_second;
                        o_res.sp_op     = sme_pkg::SP_DEC2;
                    end
                end
                sme_pkg::OP_POP: begin
                    if (i_flags.empty) begin
                        o_res.status = sme_pkg::ST_UNDER;
                    end else begin
                        o_res.sp_op = sme_pkg::SP_DEC1;
                    end
                end
                sme_pkg::OP_PUSHI: begin
                    if (i_flags.full) begin
                        o_res.status = sme_pkg::ST_OVER;
                    end else begin
                        o_res.stk_we    = 1'b1;
                        o_res.wsel      = sme_pkg::WS_AT;
                        o_res.stk_wdata = i_operand;
                        o_res.sp_op     = sme_pkg::SP_INC;
                    end
                end
                default: begin
                    // noop and unused codes
                end
            endcase
        end
    end

endmodule

FILE: src/stack_machine_execute.sv
// top level of the stack machine executor
// Executes one stack-machine instruction per request and returns one result per request.
// An instruction is taken into an input register and executed from there, so the block
// runs one instruction per clock while the output is not stalled and no load waits. The
// two top stack entries are read from the stack memory with a registered read, addressed
// by the next stack pointer and bypassed from the write of the same cycle. The data memory
// has one registered read port that follows the current top of stack: a load that comes
// directly after another executed instruction waits for that read, any other instruction
// does not. After reset the data memory is cleared one word per cycle, and no request is
// taken until that is done.
module stack_machine_execute #(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_WORDS   = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sme_pkg::WORD_W-1:0]   i_s_tdata,  // operand[31:0]
    input  logic [sme_pkg::CMD_W-1:0]    i_s_tuser,  // cmd[3:0]
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // top_value[31:0], stack_depth[38:32], mem_value[70:39], halted[71]
    output logic [71:0]                  o_m_tdata,
    output logic [sme_pkg::STATUS_W-1:0] o_m_tuser   // status[2:0]
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CW = $clog2(MEM_WORDS + 1);
    localparam int WW = sme_pkg::WORD_W;

    // input register
    logic                       r_in_valid;
    logic [sme_pkg::CMD_W-1:0]  r_cmd;
    logic [WW-1:0]              r_operand;

    // result register
    logic                       r_out_valid;
    sme_pkg::t_status           r_status;
    logic [WW-1:0]              r_mem_value;

    // machine state
    logic [PW-1:0]              r_sp;
    logic                       r_halt;
    logic [WW-1:0]              r_skip;
    logic [CW-1:0]              r_clr_cnt;

    // stack memory and its read registers
    logic [WW-1:0]              r_stack [STACK_DEPTH];
    logic [WW-1:0]              r_rd_top;
    logic [WW-1:0]              r_rd_second;
    logic                       r_byp_top;
    logic                       r_byp_second;
    logic [WW-1:0]              r_byp_data;

    // data memory and its read register
    logic [WW-1:0]              r_dmem [MEM_WORDS];
    logic [WW-1:0]              r_dm_data;
    logic                       r_dm_ok;

    logic                       w_clearing;
    logic                       w_exec;
    logic [WW-1:0]              w_top;
    logic [WW-1:0]              w_second;
    sme_pkg::t_step_flags       w_flags;
    sme_pkg::t_step_res         w_res;
    logic [PW-1:0]              n_sp;
    logic [SW-1:0]              w_wr_addr;
    logic [SW-1:0]              w_rd_addr_top;
    logic [SW-1:0]              w_rd_addr_second;
    logic [PW+sme_pkg::DEPTH_W-1:0] w_sp_wide;
    logic [WW-1:0]              w_top_out;

    assign w_clearing = (r_clr_cnt != CW'(MEM_WORDS));
    assign w_top      = r_byp_top ? r_byp_data : r_rd_top;
    assign w_second   = r_byp_second ? r_byp_data : r_rd_second;

    assign w_flags.empty   = (r_sp == '0);
    assign w_flags.lt2     = (r_sp < PW'(2));
    assign w_flags.full    = (r_sp >= PW'(STACK_DEPTH));
    assign w_flags.addr_ok = (w_top < WW'(MEM_WORDS));
    assign w_flags.dm_ok   = r_dm_ok;
    assign w_flags.halted  = r_halt;

    sme_step u_step (
        .i_cmd     (r_cmd),
        .i_operand (r_operand),
        .i_top     (w_top),
        .i_second  (w_second),
        .i_dm_data (r_dm_data),
        .i_skip    (r_skip),
        .i_flags   (w_flags),
        .o_res     (w_res)
    );

    assign w_exec     = r_in_valid && !w_res.wait_dm && (!r_out_valid || i_m_tready);
    assign o_s_tready = !w_clearing && (!r_in_valid || w_exec);

    always_comb begin
        case (w_res.sp_op)
            sme_pkg::SP_INC:  n_sp = r_sp + PW'(1);
            sme_pkg::SP_DEC1: n_sp = r_sp - PW'(1);
            sme_pkg::SP_DEC2: n_sp = r_sp - PW'(2);
            default:          n_sp = r_sp;
        endcase
    end

    always_comb begin
        case (w_res.wsel)
            sme_pkg::WS_M1: w_wr_addr = SW'(r_sp - PW'(1));
            sme_pkg::WS_M2: w_wr_addr = SW'(r_sp - PW'(2));
            default:        w_wr_addr = SW'(r_sp);
        endcase
    end

    assign w_rd_addr_top    = SW'(n_sp - PW'(1));
    assign w_rd_addr_second = SW'(n_sp - PW'(2));

    // handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_exec) begin
                r_in_valid <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_cmd     <= i_s_tuser;
            r_operand <= i_s_tdata;
        end
        if (w_exec) begin
            r_status    <= w_res.status;
            r_mem_value <= w_res.mem_value;
        end
    end

    // machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_halt       <= 1'b0;
            r_skip       <= '0;
            r_clr_cnt    <= '0;
            r_dm_ok      <= 1'b0;
            r_byp_top    <= 1'b0;
            r_byp_second <= 1'b0;
        end else begin
            if (w_clearing) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end
            // the data read stays good while the top of stack does not change
            r_dm_ok <= !w_exec && !w_clearing;
            if (w_exec) begin
                r_sp         <= n_sp;
                r_halt       <= w_res.halt;
                r_skip       <= w_res.skip;
                r_byp_top    <= w_res.stk_we && (w_wr_addr == w_rd_addr_top);
                r_byp_second <= w_res.stk_we && (w_wr_addr == w_rd_addr_second);
            end
        end
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_exec && w_res.stk_we) begin
            r_stack[w_wr_addr] <= w_res.stk_wdata;
        end
        if (w_exec) begin
            r_rd_top    <= r_stack[w_rd_addr_top];
            r_rd_second <= r_stack[w_rd_addr_second];
            r_byp_data  <= w_res.stk_wdata;
        end
    end

    // data memory: cleared after reset, read port follows the top of stack
    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_dmem[r_clr_cnt[AW-1:0]] <= '0;
        end else if (w_exec && w_res.dm_we) begin
            r_dmem[w_top[AW-1:0]] <= w_second;
        end
        r_dm_data <= r_dmem[w_top[AW-1:0]];
    end

    assign w_sp_wide = (PW + sme_pkg::DEPTH_W)'(r_sp);
    assign w_top_out = (r_sp == '0) ? '0 : w_top;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {r_halt, r_mem_value, w_sp_wide[sme_pkg::DEPTH_W-1:0], w_top_out};

endmodule

FILE: tb/sv/sme_exec_checker.sv
// checker of the stack machine executor: predicts each result and compares it with the output
`timescale 1ns / 1ps
module sme_exec_checker
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_WORDS   = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [WORD_W-1:0]   i_s_tdata,   // operand[31:0]
    input  logic [CMD_W-1:0]    i_s_tuser,   // cmd[3:0]
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // top_value[31:0], stack_depth[38:32], mem_value[70:39], halted[71]
    input  logic [71:0]         i_m_tdata,
    input  logic [STATUS_W-1:0] i_m_tuser,   // status[2:0]
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct {
        t_status            status;
        logic [WORD_W-1:0]  top_value;
        logic [DEPTH_W-1:0] depth;
        logic [WORD_W-1:0]  mem_value;
        logic               halted;
    } t_exec_result;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] data_mem  [MEM_WORDS];
    int unsigned       sp;
    logic [WORD_W-1:0] skip_left;
    logic              halted;
    t_exec_result      result_q [$];
    int                errors = 0;

    assign o_errors = errors;

    function automatic void check_field(string name, logic [WORD_W-1:0] expv,
                                        logic [WORD_W-1:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expv, actv);
            errors++;
        end
    endfunction

    task automatic execute_instr(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] opnd);
        t_exec_result      r;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        r.status    = ST_OK;
        r.mem_value = '0;
        if (halted) begin
            r.status = ST_HALTED;
        end else if (skip_left != 0) begin
            skip_left--;
            r.status = ST_SKIP;
        end else begin
            case (cmd)
                OP_HALT: begin
                    halted = 1'b1;
                end
                OP_ADD, OP_NOR: begin
                    if (sp < 2) begin
                        r.status = ST_UNDER;
                    end else begin
                        a = stack_mem[sp-1];
                        b = stack_mem[sp-2];
                        stack_mem[sp-2] = (cmd == OP_ADD) ? a + b : ~(a | b);
                        sp--;
                    end
                end
                OP_IFZ: begin
                    if (sp == 0) begin
                        r.status = ST_UNDER;
                    end else begin
                        a = stack_mem[sp-1];
                        sp--;
                        // a negative count skips nothing
                        if (a == 0 && !opnd[WORD_W-1])
                            skip_left = opnd;
                    end
                end
                OP_LOAD: begin
                    if (sp == 0) begin
                        r.status = ST_UNDER;
                    end else begin
                        a = stack_mem[sp-1];
                        // negative addresses compare as huge unsigned values
                        if (a >= MEM_WORDS) begin
                            r.status = ST_BAD_ADDR;
                        end else begin
                            r.mem_value = data_mem[a];
                            stack_mem[sp-1] = data_mem[a];
                        end
                    end
                end
                OP_STORE: begin
                    if (sp < 2) begin
                        r.status = ST_UNDER;
                    end else begin
                        a = stack_mem[sp-1];
                        b = stack_mem[sp-2];
                        if (a >= MEM_WORDS) begin
                            r.status = ST_BAD_ADDR;
                        end else begin
                            data_mem[a] = b;
                            r.mem_value = b;
                            sp -= 2;
                        end
                    end
                end
                OP_POP: begin
                    if (sp == 0)
                        r.status = ST_UNDER;
                    else
                        sp--;
                end
                OP_PUSHI: begin
                    if (sp >= STACK_DEPTH) begin
                        r.status = ST_OVER;
                    end else begin
                        stack_mem[sp] = opnd;
                        sp++;
                    end
                end
                default: ;   // noop and the unused codes
            endcase
        end
        r.top_value = (sp != 0) ? stack_mem[sp-1] : '0;
        r.depth     = sp[DEPTH_W-1:0];
        r.halted    = halted;
        result_q.push_back(r);
    endtask

    task automatic compare_result();
        t_exec_result e;
        if (result_q.size() == 0) begin
            $display("%0t: result with no request outstanding: expected none, actual %h %h",
                     $time, i_m_tuser, i_m_tdata);
            errors++;
        end else begin
            e = result_q.pop_front();
            check_field("status", WORD_W'(e.status), WORD_W'(i_m_tuser));
            check_field("top_value", e.top_value, i_m_tdata[31:0]);
            check_field("stack_depth", WORD_W'(e.depth), WORD_W'(i_m_tdata[38:32]));
            check_field("mem_value", e.mem_value, i_m_tdata[70:39]);
            check_field("halted", WORD_W'(e.halted), WORD_W'(i_m_tdata[71]));
        end
    endtask

    initial begin
        for (int i = 0; i < MEM_WORDS; i++)
            data_mem[i] = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sp        = 0;
            skip_left = '0;
            halted    = 1'b0;
            result_q.delete();
            o_pending <= 0;
        end else begin
            // a result can never belong to a request taken at the same edge
            if (i_m_tvalid && i_m_tready)
                compare_result();
            if (i_s_tvalid && i_s_tready)
                execute_instr(i_s_tuser, i_s_tdata);
            o_pending <= result_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top of the stack machine executor: clock, reset, instruction stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
    import sme_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int MEM_WORDS    = 256;
    localparam int RANDOM_ITEMS = 1950;
    localparam int LAST_CODE    = 15;   // codes above noop execute as noop
    localparam int MAX_SKIP     = 6;
    localparam int HOLD_AT      = 2000;
    localparam int HOLD_CYCLES  = 300;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata;   // operand[31:0]
    logic [CMD_W-1:0]    s_tuser;   // cmd[3:0]
    logic                m_tvalid;
    logic                m_tready;
    // top_value[31:0], stack_depth[38:32], mem_value[70:39], halted[71]
    logic [71:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;   // status[2:0]
    int                  errors;
    int                  pending;
    int                  sent;
    bit                  bursty;

    stack_machine_execute #(
        .STACK_DEPTH(STACK_DEPTH),
        .MEM_WORDS  (MEM_WORDS)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    sme_exec_checker #(
        .STACK_DEPTH(STACK_DEPTH),
        .MEM_WORDS  (MEM_WORDS)
    ) i_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata (m_tdata),
        .i_m_tuser (m_tuser),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_addr();
        case ($urandom_range(0, 19))
            0:                return MEM_WORDS;
            1:                return $urandom_range(MEM_WORDS + 1, 32'h7FFF_FFFF);
            2:                return {1'b1, 31'($urandom)};
            3:                return MEM_WORDS - 1;
            4, 5, 6, 7, 8, 9: return $urandom_range(0, 7);
            default:          return $urandom_range(0, MEM_WORDS - 1);
        endcase
    endfunction

    // zero, a short skip or a negative count; long skips would starve the run
    function automatic logic [WORD_W-1:0] skip_operand();
        case ($urandom_range(0, 3))
            0:       return '0;
            3:       return {1'b1, 31'($urandom)};
            default: return $urandom_range(1, MAX_SKIP);
        endcase
    endfunction

    task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] operand);
        int gap;
        if (sent % 150 == 0)
            bursty = ($urandom_range(0, 2) == 0);
        if (bursty) begin
            gap = 0;
        end else begin
            case ($urandom_range(0, 19))
                0:                gap = $urandom_range(8, 30);
                1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
                default:          gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= operand;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side: random stalls, a few long ones, and one long hold-off
    initial begin : result_side
        int cycles;
        int on_len;
        int off_len;
        bit held;
        cycles   = 0;
        held     = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        m_tready <= 1'b1;
        forever begin
            on_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
            repeat (on_len) @(posedge clk);
            cycles += on_len;
            case ($urandom_range(0, 19))
                0:             off_len = $urandom_range(10, 40);
                1, 2, 3, 4, 5: off_len = $urandom_range(1, 3);
                default:       off_len = 0;
            endcase
            if (!held && cycles >= HOLD_AT) begin
                held    = 1'b1;
                off_len = HOLD_CYCLES;
            end
            if (off_len > 0) begin
                m_tready <= 1'b0;
                repeat (off_len) @(posedge clk);
                cycles += off_len;
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int                first_random;
        int                kind;
        int                n;
        bit                paused;
        logic [CMD_W-1:0]  cmd;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_NOOP;
        rst_n    <= 1'b0;
        sent   = 0;
        bursty = 1'b0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack: everything that pops underflows
        send_instr(OP_POP, '0);
        send_instr(OP_ADD, '0);
        send_instr(OP_NOR, '0);
        send_instr(OP_IFZ, 32'd5);
        send_instr(OP_LOAD, '0);
        send_instr(OP_STORE, '0);
        send_instr(OP_PUSHI, 32'h7FFF_FFFF);
        send_instr(OP_PUSHI, 32'd1);
        send_instr(OP_ADD, '0);              // wraps to the most negative word
        send_instr(OP_PUSHI, '0);
        send_instr(OP_NOR, '0);
        send_instr(OP_STORE, '0);            // one entry only
        send_instr(OP_PUSHI, MEM_WORDS);
        send_instr(OP_STORE, '0);            // address just past the end
        send_instr(OP_POP, '0);
        send_instr(OP_PUSHI, MEM_WORDS - 1);
        send_instr(OP_STORE, '0);
        send_instr(OP_PUSHI, MEM_WORDS - 1);
        send_instr(OP_LOAD, '0);
        send_instr(OP_PUSHI, 32'h8000_0000);
        send_instr(OP_LOAD, '0);             // negative address
        send_instr(OP_IFZ, 32'h7FFF_FFFF);   // nonzero top, nothing skipped
        send_instr(OP_PUSHI, '0);
        send_instr(OP_IFZ, 32'h8000_0000);   // negative count skips nothing
        send_instr(OP_PUSHI, '0);
        send_instr(OP_IFZ, 32'd3);
        send_instr(OP_HALT, '0);             // discarded while skipping
        send_instr(4'(LAST_CODE), 32'hFFFF_FFFF);
        send_instr(OP_PUSHI, 32'd5);
        send_instr(4'(LAST_CODE), '0);       // unused code runs as noop
        wait_drained();

        first_random = sent;
        while (sent - first_random < RANDOM_ITEMS) begin
            if (!paused && sent - first_random >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_instr(OP_PUSHI, $urandom);
                send_instr(OP_PUSHI, rand_addr());
                send_instr(OP_STORE, $urandom);
            end else if (kind < 50) begin
                send_instr(OP_PUSHI, rand_addr());
                send_instr(OP_LOAD, $urandom);
            end else if (kind < 65) begin
                send_instr(OP_PUSHI, $urandom);
                send_instr(OP_PUSHI, $urandom);
                send_instr($urandom_range(0, 1) ? OP_ADD : OP_NOR, $urandom);
            end else if (kind < 75) begin
                send_instr(OP_PUSHI, $urandom_range(0, 1) ? '0 : $urandom);
                send_instr(OP_IFZ, skip_operand());
            end else if (kind < 79) begin
                // flush any pending skip, then a skip that hides halts
                repeat (MAX_SKIP) send_instr(OP_NOOP, $urandom);
                send_instr(OP_POP, $urandom);
                send_instr(OP_PUSHI, '0);
                n = $urandom_range(1, 5);
                send_instr(OP_IFZ, n);
                repeat (n) send_instr($urandom_range(0, 1) ? OP_HALT : 4'($urandom), $urandom);
            end else if (kind < 82) begin
                repeat (STACK_DEPTH + 2) send_instr(OP_PUSHI, $urandom);
            end else if (kind < 85) begin
                repeat (STACK_DEPTH + 2) send_instr(OP_POP, $urandom);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    cmd = 4'($urandom_range(OP_ADD, LAST_CODE));
                    send_instr(cmd, (cmd == OP_IFZ) ? skip_operand() : $urandom);
                end
            end
        end

        // halt for real, then a few requests that must be ignored
        repeat (MAX_SKIP) send_instr(OP_NOOP, $urandom);
        send_instr(OP_HALT, $urandom);
        repeat (5) send_instr(4'($urandom), $urandom);
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
